// ===== src/i2p_pkg.sv =====
`timescale 1ns / 1ps

package i2p_pkg;

  // Default operator stack depth
  localparam int unsigned DefStackDepth = 16;

  // ASCII characters the block recognizes
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChCaret  = 8'h5E;
  localparam logic [7:0] ChOpen   = 8'h28;
  localparam logic [7:0] ChClose  = 8'h29;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChNul    = 8'h00;

  // Stack entry codes
  typedef enum logic [2:0] {
    OP_OPEN = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_POW  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_PAREN    = 2'd1,
    ERR_CHAR     = 2'd2,
    ERR_OVERFLOW = 2'd3
  } err_e;

  // Character class of the held item
  typedef enum logic [2:0] {
    KIND_DIGIT,
    KIND_END,
    KIND_OPEN,
    KIND_CLOSE,
    KIND_OP,
    KIND_BLANK,
    KIND_BAD
  } kind_e;

  // Next stack action for the held item
  typedef enum logic [2:0] {
    ACT_POP,
    ACT_PUSH,
    ACT_DROP,
    ACT_NONE,
    ACT_TERM,
    ACT_FAIL
  } act_e;

  // Source of an emitted character
  typedef enum logic [1:0] {
    SEL_SYMBOL,
    SEL_SPACE,
    SEL_TOP,
    SEL_NUL
  } sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SPACE,
    ST_WORK,
    ST_OPSPACE
  } state_e;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_expr;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
    logic       expr_done;
    logic [1:0] error_code;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic emit;
    sel_e sel;
    logic last;
    logic push;
    logic pop;
    logic fail;
    logic set_num;
    logic clr_num;
    logic clr_disc;
  } ctrl_cmd_t;

  typedef struct packed {
    kind_e kind;
    act_e  act;
    logic  discarding;
    logic  in_number;
    logic  out_free;
  } dp_status_t;

  function automatic logic [1:0] op_prec(op_e op);
    logic [1:0] p;
    case (op)
      OP_ADD, OP_SUB: p = 2'd1;
      OP_MUL, OP_DIV: p = 2'd2;
      OP_POW:         p = 2'd3;
      default:        p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] op_char(op_e op);
    logic [7:0] c;
    case (op)
      OP_OPEN: c = ChOpen;
      OP_ADD:  c = ChPlus;
      OP_SUB:  c = ChMinus;
      OP_MUL:  c = ChStar;
      OP_DIV:  c = ChSlash;
      OP_POW:  c = ChCaret;
      default: c = ChNul;
    endcase
    return c;
  endfunction

endpackage

// ===== src/i2p_ctrl.sv =====
`timescale 1ns / 1ps

module i2p_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  i2p_pkg::dp_status_t   status_i,
  output i2p_pkg::ctrl_cmd_t    cmd_o
);

  i2p_pkg::state_e state_q, state_d;
  logic            quiet;

  // A space is the last result when the following stack action emits nothing
  assign quiet = (status_i.act == i2p_pkg::ACT_PUSH) ||
                 (status_i.act == i2p_pkg::ACT_DROP) ||
                 (status_i.act == i2p_pkg::ACT_NONE);

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i2p_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequence one item through decode, closing space and stack work
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      i2p_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = i2p_pkg::ST_DECODE;
        end
      end
      i2p_pkg::ST_DECODE: begin
        if (status_i.discarding) begin
          cmd_o.clr_disc = (status_i.kind == i2p_pkg::KIND_END);
          state_d        = i2p_pkg::ST_IDLE;
        end else if (status_i.kind == i2p_pkg::KIND_DIGIT) begin
          if (status_i.out_free) begin
            cmd_o.emit    = 1'b1;
            cmd_o.sel     = i2p_pkg::SEL_SYMBOL;
            cmd_o.last    = 1'b1;
            cmd_o.set_num = 1'b1;
            state_d       = i2p_pkg::ST_IDLE;
          end
        end else if (status_i.in_number) begin
          state_d = i2p_pkg::ST_SPACE;
        end else begin
          state_d = i2p_pkg::ST_WORK;
        end
      end
      i2p_pkg::ST_SPACE: begin
        if (status_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.sel     = i2p_pkg::SEL_SPACE;
          cmd_o.last    = quiet;
          cmd_o.clr_num = 1'b1;
          state_d       = i2p_pkg::ST_WORK;
        end
      end
      i2p_pkg::ST_WORK: begin
        case (status_i.act)
          i2p_pkg::ACT_POP: begin
            if (status_i.out_free) begin
              cmd_o.emit = 1'b1;
              cmd_o.sel  = i2p_pkg::SEL_TOP;
              cmd_o.pop  = 1'b1;
              state_d    = i2p_pkg::ST_OPSPACE;
            end
          end
          i2p_pkg::ACT_PUSH: begin
            cmd_o.push = 1'b1;
            state_d    = i2p_pkg::ST_IDLE;
          end
          i2p_pkg::ACT_DROP: begin
            cmd_o.pop = 1'b1;
            state_d   = i2p_pkg::ST_IDLE;
          end
          i2p_pkg::ACT_TERM: begin
            if (status_i.out_free) begin
              cmd_o.emit = 1'b1;
              cmd_o.sel  = i2p_pkg::SEL_NUL;
              cmd_o.last = 1'b1;
              state_d    = i2p_pkg::ST_IDLE;
            end
          end
          i2p_pkg::ACT_FAIL: begin
            if (status_i.out_free) begin
              cmd_o.emit = 1'b1;
              cmd_o.sel  = i2p_pkg::SEL_NUL;
              cmd_o.last = 1'b1;
              cmd_o.fail = 1'b1;
              state_d    = i2p_pkg::ST_IDLE;
            end
          end
          default: begin
            state_d = i2p_pkg::ST_IDLE;
          end
        endcase
      end
      i2p_pkg::ST_OPSPACE: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = i2p_pkg::SEL_SPACE;
          cmd_o.last = quiet;
          state_d    = i2p_pkg::ST_WORK;
        end
      end
      default: begin
        state_d = i2p_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/i2p_datapath.sv =====
`timescale 1ns / 1ps

module i2p_datapath #(
  parameter int unsigned STACK_DEPTH = i2p_pkg::DefStackDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  i2p_pkg::in_item_t    in_item_i,
  input  i2p_pkg::ctrl_cmd_t   cmd_i,
  output i2p_pkg::dp_status_t  status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output i2p_pkg::out_item_t   out_item_o
);

  localparam int unsigned IdxW = $clog2(STACK_DEPTH);
  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);

  i2p_pkg::in_item_t  item_q;
  i2p_pkg::op_e       stack_q [STACK_DEPTH];
  logic [CntW-1:0]    count_q, count_d;
  logic               in_number_q, in_number_d;
  logic               discarding_q, discarding_d;
  logic               out_valid_q, out_valid_d;
  i2p_pkg::out_item_t out_q;

  i2p_pkg::kind_e     kind;
  i2p_pkg::op_e       in_op;
  i2p_pkg::op_e       push_code;
  i2p_pkg::op_e       top;
  i2p_pkg::act_e      act;
  i2p_pkg::err_e      act_err;
  logic [IdxW-1:0]    top_idx;
  logic               has_top;
  logic               top_open;
  logic               full;
  logic               out_free;

  // Classify the held character
  always_comb begin
    in_op = i2p_pkg::OP_ADD;
    if (item_q.end_of_expr) begin
      kind = i2p_pkg::KIND_END;
    end else if (item_q.symbol >= i2p_pkg::ChZero && item_q.symbol <= i2p_pkg::ChNine) begin
      kind = i2p_pkg::KIND_DIGIT;
    end else if (item_q.symbol == i2p_pkg::ChSpace ||
                 (item_q.symbol >= i2p_pkg::ChTab && item_q.symbol <= i2p_pkg::ChCr)) begin
      kind = i2p_pkg::KIND_BLANK;
    end else begin
      case (item_q.symbol)
        i2p_pkg::ChOpen:  kind = i2p_pkg::KIND_OPEN;
        i2p_pkg::ChClose: kind = i2p_pkg::KIND_CLOSE;
        i2p_pkg::ChPlus: begin
          kind  = i2p_pkg::KIND_OP;
          in_op = i2p_pkg::OP_ADD;
        end
        i2p_pkg::ChMinus: begin
          kind  = i2p_pkg::KIND_OP;
          in_op = i2p_pkg::OP_SUB;
        end
        i2p_pkg::ChStar: begin
          kind  = i2p_pkg::KIND_OP;
          in_op = i2p_pkg::OP_MUL;
        end
        i2p_pkg::ChSlash: begin
          kind  = i2p_pkg::KIND_OP;
          in_op = i2p_pkg::OP_DIV;
        end
        i2p_pkg::ChCaret: begin
          kind  = i2p_pkg::KIND_OP;
          in_op = i2p_pkg::OP_POW;
        end
        default: kind = i2p_pkg::KIND_BAD;
      endcase
    end
  end

  assign push_code = (kind == i2p_pkg::KIND_OPEN) ? i2p_pkg::OP_OPEN : in_op;

  // Read the top of stack
  assign top_idx  = IdxW'(count_q - CntW'(1));
  assign top      = stack_q[top_idx];
  assign has_top  = (count_q != '0);
  assign top_open = has_top && (top == i2p_pkg::OP_OPEN);
  assign full     = (count_q == CntW'(STACK_DEPTH));

  // Pick the next stack action
  always_comb begin
    act     = i2p_pkg::ACT_NONE;
    act_err = i2p_pkg::ERR_NONE;
    case (kind)
      i2p_pkg::KIND_END: begin
        if (!has_top) begin
          act = i2p_pkg::ACT_TERM;
        end else if (top_open) begin
          act     = i2p_pkg::ACT_FAIL;
          act_err = i2p_pkg::ERR_PAREN;
        end else begin
          act = i2p_pkg::ACT_POP;
        end
      end
      i2p_pkg::KIND_OPEN: begin
        if (full) begin
          act     = i2p_pkg::ACT_FAIL;
          act_err = i2p_pkg::ERR_OVERFLOW;
        end else begin
          act = i2p_pkg::ACT_PUSH;
        end
      end
      i2p_pkg::KIND_CLOSE: begin
        if (!has_top) begin
          act     = i2p_pkg::ACT_FAIL;
          act_err = i2p_pkg::ERR_PAREN;
        end else if (top_open) begin
          act = i2p_pkg::ACT_DROP;
        end else begin
          act = i2p_pkg::ACT_POP;
        end
      end
      i2p_pkg::KIND_OP: begin
        if (has_top && !top_open &&
            (i2p_pkg::op_prec(top) >= i2p_pkg::op_prec(in_op))) begin
          act = i2p_pkg::ACT_POP;
        end else if (full) begin
          act     = i2p_pkg::ACT_FAIL;
          act_err = i2p_pkg::ERR_OVERFLOW;
        end else begin
          act = i2p_pkg::ACT_PUSH;
        end
      end
      i2p_pkg::KIND_BAD: begin
        act     = i2p_pkg::ACT_FAIL;
        act_err = i2p_pkg::ERR_CHAR;
      end
      default: act = i2p_pkg::ACT_NONE;
    endcase
  end

  // Latch the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_item_i;
    end
  end

  // Write the stack entry at the fill level
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      stack_q[count_q[IdxW-1:0]] <= push_code;
    end
  end

  // Advance count and flags
  always_comb begin
    count_d      = count_q;
    in_number_d  = in_number_q;
    discarding_d = discarding_q;
    if (cmd_i.fail) begin
      count_d      = '0;
      in_number_d  = 1'b0;
      discarding_d = 1'b1;
    end else begin
      if (cmd_i.push) begin
        count_d = count_q + CntW'(1);
      end else if (cmd_i.pop) begin
        count_d = count_q - CntW'(1);
      end
      if (cmd_i.set_num) begin
        in_number_d = 1'b1;
      end else if (cmd_i.clr_num) begin
        in_number_d = 1'b0;
      end
      if (cmd_i.clr_disc) begin
        discarding_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      in_number_q  <= 1'b0;
      discarding_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      in_number_q  <= in_number_d;
      discarding_q <= discarding_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Output register: free once empty or being taken
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      case (cmd_i.sel)
        i2p_pkg::SEL_SYMBOL: out_q.out_char <= item_q.symbol;
        i2p_pkg::SEL_SPACE:  out_q.out_char <= i2p_pkg::ChSpace;
        i2p_pkg::SEL_TOP:    out_q.out_char <= i2p_pkg::op_char(top);
        default:             out_q.out_char <= i2p_pkg::ChNul;
      endcase
      out_q.last_of_run <= cmd_i.last;
      out_q.expr_done   <= (cmd_i.sel == i2p_pkg::SEL_NUL);
      out_q.error_code  <= (cmd_i.sel == i2p_pkg::SEL_NUL) ? act_err : i2p_pkg::ERR_NONE;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign status_o.kind       = kind;
  assign status_o.act        = act;
  assign status_o.discarding = discarding_q;
  assign status_o.in_number  = in_number_q;
  assign status_o.out_free   = out_free;

endmodule

// ===== src/infix_to_postfix_converter.sv =====
`timescale 1ns / 1ps

// Streaming infix-to-postfix converter (shunting-yard).
// Input channel in_valid_i/in_ready_o carries one item: an ASCII symbol, or
// an end-of-expression marker. Output channel out_valid_o/out_ready_i carries
// postfix characters; last_of_run flags the final result of an item, and
// expr_done with error_code closes the expression (NUL terminator or error).
// An item is taken in the idle state and decoded in the next cycle. A digit
// leaves from the decode state once the output register is free. Other items
// go on to the stack work state, through a closing space first when a digit
// run ends; each popped operator gives its character, then a space, all
// serialized through the single output register. An item that ends in a
// push, a drop or no stack action gives no result in stack work. An item
// dropped while discarding returns to idle from decode. The next item is
// accepted in the cycle after the sequencer finishes, even while the last
// result still waits to be taken; no new item is taken while one is in work.
// Reset clears the stack fill level, the digit-run flag, the discard flag and
// the output valid; stack entries need no clearing.
module infix_to_postfix_converter #(
  parameter int unsigned STACK_DEPTH = i2p_pkg::DefStackDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  i2p_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output i2p_pkg::out_item_t out_item_o
);

  i2p_pkg::ctrl_cmd_t  cmd;
  i2p_pkg::dp_status_t status;

  i2p_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  i2p_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // Never overwrite a result that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_o || out_ready_i))
    else $error("result emitted over a pending result");

  // Stack changes are exclusive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.push, cmd.pop, cmd.fail}))
    else $error("conflicting stack commands");

  // A closing result is always the last of its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.expr_done) |-> out_item_o.last_of_run)
    else $error("expression closed before last result");

  // Error codes only ride on a NUL closing result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.error_code != i2p_pkg::ERR_NONE)) |->
      (out_item_o.expr_done && (out_item_o.out_char == i2p_pkg::ChNul)))
    else $error("error code on an ordinary result");

endmodule

// ===== verif/postfix_checker.sv =====
`timescale 1ns / 1ps

module postfix_checker #(
  parameter int unsigned STACK_DEPTH = i2p_pkg::DefStackDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  i2p_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  i2p_pkg::out_item_t out_item_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        items_o,
  output int unsigned        results_o,
  output int unsigned        closed_o,
  output int unsigned        aborted_o
);

  // Mirror of the converter state
  i2p_pkg::op_e op_stack [32];
  int unsigned  op_depth;
  bit           in_digits;
  bit           skipping;

  // Postfix characters still owed by the block, oldest first
  i2p_pkg::out_item_t postfix_q [$];
  // Characters caused by the item being predicted
  i2p_pkg::out_item_t run_q [$];

  int unsigned fails;
  int unsigned items;
  int unsigned results;
  int unsigned closed;
  int unsigned aborted;

  function automatic logic [1:0] op_rank(i2p_pkg::op_e code);
    case (code)
      i2p_pkg::OP_POW:                 return 2'd3;
      i2p_pkg::OP_MUL, i2p_pkg::OP_DIV: return 2'd2;
      i2p_pkg::OP_ADD, i2p_pkg::OP_SUB: return 2'd1;
      default:                         return 2'd0;
    endcase
  endfunction

  function automatic logic [7:0] op_symbol(i2p_pkg::op_e code);
    case (code)
      i2p_pkg::OP_ADD: return i2p_pkg::ChPlus;
      i2p_pkg::OP_SUB: return i2p_pkg::ChMinus;
      i2p_pkg::OP_MUL: return i2p_pkg::ChStar;
      i2p_pkg::OP_DIV: return i2p_pkg::ChSlash;
      i2p_pkg::OP_POW: return i2p_pkg::ChCaret;
      default:         return i2p_pkg::ChOpen;
    endcase
  endfunction

  // Map an arithmetic operator character to its code; OP_OPEN means "not one"
  function automatic i2p_pkg::op_e operator_code(logic [7:0] s);
    case (s)
      i2p_pkg::ChPlus:  return i2p_pkg::OP_ADD;
      i2p_pkg::ChMinus: return i2p_pkg::OP_SUB;
      i2p_pkg::ChStar:  return i2p_pkg::OP_MUL;
      i2p_pkg::ChSlash: return i2p_pkg::OP_DIV;
      i2p_pkg::ChCaret: return i2p_pkg::OP_POW;
      default:          return i2p_pkg::OP_OPEN;
    endcase
  endfunction

  task automatic put_char(input logic [7:0] ch, input logic done,
                          input i2p_pkg::err_e err);
    i2p_pkg::out_item_t r;
    r.out_char    = ch;
    r.last_of_run = 1'b0;
    r.expr_done   = done;
    r.error_code  = err;
    run_q.push_back(r);
    if (done) begin
      if (err == i2p_pkg::ERR_NONE) closed++;
      else aborted++;
    end
  endtask

  // Emit the top operator followed by its separating space
  task automatic pop_operator();
    op_depth--;
    put_char(op_symbol(op_stack[op_depth]), 1'b0, i2p_pkg::ERR_NONE);
    put_char(i2p_pkg::ChSpace, 1'b0, i2p_pkg::ERR_NONE);
  endtask

  // Drop the expression: clear the stack and skip items until the end item
  task automatic abort_expr(input i2p_pkg::err_e err);
    op_depth  = 0;
    in_digits = 1'b0;
    skipping  = 1'b1;
    put_char(i2p_pkg::ChNul, 1'b1, err);
  endtask

  task automatic push_operator(input i2p_pkg::op_e code);
    if (op_depth >= STACK_DEPTH) begin
      abort_expr(i2p_pkg::ERR_OVERFLOW);
    end else begin
      op_stack[op_depth] = code;
      op_depth++;
    end
  endtask

  // Pop operators down to the nearest opener, leaving the opener in place
  task automatic unwind_to_open();
    while (op_depth > 0 && op_stack[op_depth - 1] != i2p_pkg::OP_OPEN) pop_operator();
  endtask

  // Advance the mirror by one accepted item and queue the characters it causes
  task automatic shunt_symbol(input i2p_pkg::in_item_t it);
    logic [7:0]         s;
    i2p_pkg::op_e       code;
    i2p_pkg::out_item_t r;
    s = it.symbol;
    code = operator_code(s);
    run_q.delete();
    if (skipping) begin
      if (it.end_of_expr) skipping = 1'b0;
    end else begin
      items++;
      if (!it.end_of_expr && s >= i2p_pkg::ChZero && s <= i2p_pkg::ChNine) begin
        in_digits = 1'b1;
        put_char(s, 1'b0, i2p_pkg::ERR_NONE);
      end else begin
        // close a digit run with a single space
        if (in_digits) begin
          in_digits = 1'b0;
          put_char(i2p_pkg::ChSpace, 1'b0, i2p_pkg::ERR_NONE);
        end
        if (it.end_of_expr) begin
          unwind_to_open();
          if (op_depth > 0) abort_expr(i2p_pkg::ERR_PAREN);
          else put_char(i2p_pkg::ChNul, 1'b1, i2p_pkg::ERR_NONE);
        end else if (s == i2p_pkg::ChOpen) begin
          push_operator(i2p_pkg::OP_OPEN);
        end else if (s == i2p_pkg::ChClose) begin
          unwind_to_open();
          if (op_depth == 0) abort_expr(i2p_pkg::ERR_PAREN);
          else op_depth--;
        end else if (code != i2p_pkg::OP_OPEN) begin
          while (op_depth > 0 && op_stack[op_depth - 1] != i2p_pkg::OP_OPEN &&
                 op_rank(op_stack[op_depth - 1]) >= op_rank(code)) begin
            pop_operator();
          end
          push_operator(code);
        end else if (s != i2p_pkg::ChSpace &&
                     (s < i2p_pkg::ChTab || s > i2p_pkg::ChCr)) begin
          abort_expr(i2p_pkg::ERR_CHAR);
        end
      end
    end
    foreach (run_q[i]) begin
      r = run_q[i];
      r.last_of_run = (i == run_q.size() - 1);
      postfix_q.push_back(r);
    end
  endtask

  // Compare one accepted character with the oldest one owed
  task automatic check_result(input i2p_pkg::out_item_t got);
    i2p_pkg::out_item_t want;
    results++;
    if (postfix_q.size() == 0) begin
      fails++;
      $display("%0t: mismatch: expected no result, got char %h last %b done %b err %0d",
               $time, got.out_char, got.last_of_run, got.expr_done, got.error_code);
    end else begin
      want = postfix_q.pop_front();
      if (got.out_char !== want.out_char || got.last_of_run !== want.last_of_run ||
          got.expr_done !== want.expr_done || got.error_code !== want.error_code) begin
        fails++;
        $display("%0t: mismatch: expected char %h last %b done %b err %0d,",
                 $time, want.out_char, want.last_of_run, want.expr_done,
                 want.error_code);
        $display("%0t:           got char %h last %b done %b err %0d",
                 $time, got.out_char, got.last_of_run, got.expr_done, got.error_code);
      end
    end
  endtask

  // Watch both channels; results leave before the item taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_depth  = 0;
      in_digits = 1'b0;
      skipping  = 1'b0;
      postfix_q.delete();
      fails   = 0;
      items   = 0;
      results = 0;
      closed  = 0;
      aborted = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result(out_item_i);
      if (in_valid_i && in_ready_i) shunt_symbol(in_item_i);
    end
    fail_count_o <= fails;
    pending_o    <= postfix_q.size();
    items_o      <= items;
    results_o    <= results;
    closed_o     <= closed;
    aborted_o    <= aborted;
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int unsigned TargetItems   = 260;
  localparam int unsigned QuietItems    = 40;
  localparam int unsigned TailCycles    = 40;
  localparam int unsigned WatchdogLimit = 2000;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               in_valid  = 1'b0;
  i2p_pkg::in_item_t  in_item   = '0;
  logic               out_ready = 1'b0;
  logic               in_ready;
  logic               out_valid;
  i2p_pkg::out_item_t out_item;

  bit          idle_on     = 1'b1;
  int unsigned stall_left  = 0;
  int unsigned idle_cycles = 0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_taken;
  int unsigned results_seen;
  int unsigned closed_cnt;
  int unsigned aborted_cnt;

  // Characters of the expression about to be sent
  i2p_pkg::in_item_t expr_q [$];

  always #5 clk_i = ~clk_i;

  infix_to_postfix_converter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  postfix_checker postfix_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_item_i  (out_item),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .items_o     (items_taken),
    .results_o   (results_seen),
    .closed_o    (closed_cnt),
    .aborted_o   (aborted_cnt)
  );

  // Stall the receiver in random bursts, starting new bursts only while idle_on is set
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready = 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 16);
      out_ready = 1'b0;
    end else begin
      out_ready = 1'b1;
    end
  end

  // Give up when no item moves on either channel for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == WatchdogLimit) begin
        $display("tb failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic i2p_pkg::in_item_t make_item(logic [7:0] s, logic term);
    i2p_pkg::in_item_t it;
    it.symbol      = s;
    it.end_of_expr = term;
    return it;
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(0, 4))
      0:       return i2p_pkg::ChPlus;
      1:       return i2p_pkg::ChMinus;
      2:       return i2p_pkg::ChStar;
      3:       return i2p_pkg::ChSlash;
      default: return i2p_pkg::ChCaret;
    endcase
  endfunction

  task automatic queue_char(input logic [7:0] s);
    expr_q.push_back(make_item(s, 1'b0));
  endtask

  task automatic queue_end(input logic [7:0] s);
    expr_q.push_back(make_item(s, 1'b1));
  endtask

  task automatic queue_text(input string txt);
    for (int i = 0; i < txt.len(); i++) queue_char(txt[i]);
  endtask

  task automatic queue_number();
    repeat ($urandom_range(1, 3)) queue_char(8'(i2p_pkg::ChZero + $urandom_range(0, 9)));
  endtask

  // Insert white space now and then: a space or one of TAB..CR
  task automatic maybe_blank();
    if ($urandom_range(0, 3) == 0) begin
      if ($urandom_range(0, 5) == 0) queue_char(i2p_pkg::ChSpace);
      else queue_char(8'(i2p_pkg::ChTab + $urandom_range(0, 4)));
    end
  endtask

  // Well-formed expression, optionally with one character corrupted
  task automatic queue_expression(input bit broken);
    int terms;
    int opens;
    int pos;
    terms = $urandom_range(1, 6);
    opens = 0;
    for (int t = 0; t < terms; t++) begin
      if (t > 0) begin
        maybe_blank();
        queue_char(random_operator());
        maybe_blank();
      end
      while (opens < 4 && $urandom_range(0, 3) == 0) begin
        queue_char(i2p_pkg::ChOpen);
        opens++;
      end
      queue_number();
      while (opens > 0 && $urandom_range(0, 2) == 0) begin
        queue_char(i2p_pkg::ChClose);
        opens--;
      end
    end
    repeat (opens) queue_char(i2p_pkg::ChClose);
    if (broken) begin
      pos = $urandom_range(0, expr_q.size() - 1);
      case ($urandom_range(0, 2))
        0:       expr_q[pos] = make_item(8'($urandom_range(0, 255)), 1'b0);
        1:       expr_q[pos] = make_item(i2p_pkg::ChOpen, 1'b0);
        default: expr_q[pos] = make_item(i2p_pkg::ChClose, 1'b0);
      endcase
    end
    queue_end(8'($urandom_range(0, 255)));
  endtask

  // Deep nesting, mixed with operators, that sometimes overflows the stack
  task automatic queue_nesting();
    int levels;
    levels = $urandom_range(6, 17);
    repeat (levels) begin
      if ($urandom_range(0, 3) == 0) begin
        queue_number();
        queue_char(random_operator());
      end
      queue_char(i2p_pkg::ChOpen);
    end
    queue_number();
    repeat (levels) queue_char(i2p_pkg::ChClose);
    queue_end(8'($urandom_range(0, 255)));
  endtask

  // Arbitrary bytes, then the end item
  task automatic queue_noise();
    repeat ($urandom_range(1, 8)) queue_char(8'($urandom_range(0, 255)));
    queue_end(8'($urandom_range(0, 255)));
  endtask

  // Offer one item, holding it until accepted; called and returns at a falling edge
  task automatic send_item(input i2p_pkg::in_item_t it);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    in_item  = it;
    in_valid = 1'b1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_queued();
    while (expr_q.size() > 0) send_item(expr_q.pop_front());
  endtask

  initial begin
    int pick;

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: all operators and parentheses, operator after a digit run,
    // stray closer, opener left at the end, invalid bytes at both extremes
    queue_text("9 ^(0-1)*2/3+4");
    queue_end(8'hFF);
    queue_text(")");
    queue_end(8'hFF);
    queue_char(i2p_pkg::ChOpen);
    queue_char(i2p_pkg::ChTab);
    queue_end(i2p_pkg::ChNul);
    queue_end(i2p_pkg::ChNul);
    queue_char(i2p_pkg::ChNul);
    queue_char(8'hFF);
    queue_end(8'h5A);
    send_queued();

    // Random: mostly well-formed expressions, some deep, broken or noisy
    while (items_taken < TargetItems) begin
      if (items_taken + QuietItems >= TargetItems) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 19);
      if (pick < 12) queue_expression(1'b0);
      else if (pick < 14) queue_nesting();
      else if (pick < 17) queue_expression(1'b1);
      else queue_noise();
      send_queued();
    end
    in_valid = 1'b0;

    // Drain the owed characters, then watch for strays
    while (pending != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);

    $display("covered %0d live items and %0d postfix characters", items_taken, results_seen);
    $display("expressions closed: %0d normally, %0d on an error", closed_cnt, aborted_cnt);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/i2p_pkg.sv
src/i2p_ctrl.sv
src/i2p_datapath.sv
src/infix_to_postfix_converter.sv
verif/postfix_checker.sv
verif/tb.sv
